// File: rtl/core/capacity_route_splitter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the capacity route splitter core checker.
// Both macros expect signals named clk and arst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef CAPACITY_ROUTE_SPLITTER_CORE_MACROS_SVH
`define CAPACITY_ROUTE_SPLITTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crs check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crs check failed");

`endif

// File: rtl/core/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// Types, constants and helper functions shared by the route splitter core.
// ----------------------------------------------------------------------------
package crs_pkg;

	localparam int MAX_NODES  = 256;
	localparam int DIST_BITS  = 24;

	localparam int NODE_W     = 8;
	localparam int IN_DIST_W  = 24;
	localparam int DEMAND_W   = 10;
	localparam int CAP_W      = 16;
	localparam int LOAD_W     = 17;
	localparam int COST_W     = 40;

	localparam int NODE_IDX_W = $clog2(MAX_NODES);
	localparam int ADDR_W     = 2 * NODE_IDX_W;
	localparam int TABLE_DEPTH = 2 ** ADDR_W;

	localparam int OPQ_DEPTH  = 4;
	localparam int OUT_DEPTH  = 4;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEPOT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

	localparam logic [NODE_W-1:0] DEPOT_RESET    = 8'd0;
	localparam logic [CAP_W-1:0]  CAPACITY_RESET = 16'd10;

	localparam logic [1:0] CMD_LOAD     = 2'd0;
	localparam logic [1:0] CMD_CUSTOMER = 2'd1;
	localparam logic [1:0] CMD_END      = 2'd2;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [NODE_W-1:0]    row_node;
		logic [NODE_W-1:0]    col_node;
		logic [IN_DIST_W-1:0] distance_value;
		logic [NODE_W-1:0]    customer;
		logic [DEMAND_W-1:0]  demand;
	} item_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [COST_W-1:0] route_cost;
		logic              last;
	} result_t;

	typedef enum logic {
		OP_WRITE,
		OP_ADVANCE
	} op_kind_t;

	// One operation for the back end: a table write or one step along the tour.
	typedef struct packed {
		op_kind_t             kind;
		logic                 in_range;
		logic [ADDR_W-1:0]    addr;
		logic [DIST_BITS-1:0] wdata;
		logic [NODE_W-1:0]    node;
		logic                 emit;
		logic                 last;
	} op_t;

	function automatic logic node_in_range(input logic [NODE_W-1:0] n);
		logic [31:0] wide;
		wide = 32'(n);
		return wide < 32'(MAX_NODES);
	endfunction

	function automatic logic [NODE_IDX_W-1:0] node_index(input logic [NODE_W-1:0] n);
		logic [31:0] wide;
		wide = 32'(n);
		return wide[NODE_IDX_W-1:0];
	endfunction

	function automatic op_t make_write(input logic [NODE_W-1:0] row,
			input logic [NODE_W-1:0] col, input logic [IN_DIST_W-1:0] val);
		op_t         op;
		logic [31:0] wide;
		wide        = 32'(val);
		op.kind     = OP_WRITE;
		op.in_range = node_in_range(row) && node_in_range(col);
		op.addr     = {node_index(row), node_index(col)};
		op.wdata    = wide[DIST_BITS-1:0];
		op.node     = col;
		op.emit     = 1'b0;
		op.last     = 1'b0;
		return op;
	endfunction

	function automatic op_t make_advance(input logic [NODE_W-1:0] from,
			input logic [NODE_W-1:0] to, input logic emit, input logic last);
		op_t op;
		op.kind     = OP_ADVANCE;
		op.in_range = node_in_range(from) && node_in_range(to);
		op.addr     = {node_index(from), node_index(to)};
		op.wdata    = '0;
		op.node     = to;
		op.emit     = emit;
		op.last     = last;
		return op;
	endfunction

endpackage

// File: rtl/core/crs_front.sv
// ----------------------------------------------------------------------------
// crs_front
// Accepts items, holds the configuration and the route load, and turns each
// item into zero, one or two back-end operations.
// ----------------------------------------------------------------------------
module crs_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  crs_pkg::item_t                  item,
	input  logic                            cfg_we,
	input  logic [crs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [crs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            q_full,
	output logic                            q_push,
	output crs_pkg::op_t                    q_data,
	output logic                            clear
);
	import crs_pkg::*;

	logic [NODE_W-1:0] depot_q;
	logic [CAP_W-1:0]  capacity_q;
	logic [LOAD_W-1:0] route_load_q;
	logic [NODE_W-1:0] prev_q;
	logic              pending_q;
	op_t               pend_op_q;

	logic              accept;
	logic [LOAD_W-1:0] load_sum;
	logic              fits;
	logic              op0_valid;
	logic              op1_valid;
	op_t               op0;
	op_t               op1;
	logic [LOAD_W-1:0] load_next;
	logic [NODE_W-1:0] prev_next;

	// A two-operation item parks its second operation until the queue can take it.
	assign full   = pending_q | q_full;
	assign accept = push & ~full;
	assign clear  = cfg_we && (cfg_index == REG_DEPOT);

	assign load_sum = route_load_q + LOAD_W'(item.demand);
	assign fits     = load_sum <= LOAD_W'(capacity_q);

	always_comb begin
		op0_valid = 1'b0;
		op1_valid = 1'b0;
		op0       = '0;
		op1       = '0;
		load_next = route_load_q;
		prev_next = prev_q;
		unique case (item.cmd)
			CMD_LOAD: begin
				op0_valid = 1'b1;
				op0       = make_write(item.row_node, item.col_node, item.distance_value);
			end
			CMD_CUSTOMER: begin
				if (item.customer != depot_q) begin
					op0_valid = 1'b1;
					prev_next = item.customer;
					if (fits) begin
						load_next = load_sum;
						op0       = make_advance(prev_q, item.customer, 1'b1, 1'b0);
					end else begin
						load_next = LOAD_W'(item.demand);
						op0       = make_advance(prev_q, depot_q, 1'b1, 1'b0);
						op1_valid = 1'b1;
						op1       = make_advance(depot_q, item.customer, 1'b1, 1'b0);
					end
				end
			end
			CMD_END: begin
				op0_valid = 1'b1;
				op1_valid = 1'b1;
				op0       = make_advance(prev_q, depot_q, 1'b0, 1'b0);
				op1       = make_advance(depot_q, depot_q, 1'b1, 1'b1);
				load_next = '0;
				prev_next = depot_q;
			end
			default: begin
			end
		endcase
	end

	assign q_push = pending_q ? ~q_full : (accept & op0_valid);
	assign q_data = pending_q ? pend_op_q : op0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depot_q      <= DEPOT_RESET;
			capacity_q   <= CAPACITY_RESET;
			route_load_q <= '0;
			prev_q       <= DEPOT_RESET;
			pending_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DEPOT) begin
					depot_q      <= cfg_data[NODE_W-1:0];
					route_load_q <= '0;
					prev_q       <= cfg_data[NODE_W-1:0];
				end else if (cfg_index == REG_CAPACITY) begin
					capacity_q <= cfg_data[CAP_W-1:0];
				end
			end else if (accept) begin
				route_load_q <= load_next;
				prev_q       <= prev_next;
			end
			if (pending_q && !q_full) begin
				pending_q <= 1'b0;
			end else if (accept && op1_valid) begin
				pending_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op1_valid) begin
			pend_op_q <= op1;
		end
	end

endmodule

// File: rtl/core/crs_op_queue.sv
// ----------------------------------------------------------------------------
// crs_op_queue
// Short first-in first-out queue of operations between front and back end.
// ----------------------------------------------------------------------------
module crs_op_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  crs_pkg::op_t wr_data,
	output logic         q_full,
	input  logic         rd_en,
	output crs_pkg::op_t rd_data,
	output logic         q_empty
);
	import crs_pkg::*;

	localparam int PTR_W = $clog2(OPQ_DEPTH);
	localparam int CNT_W = $clog2(OPQ_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OPQ_DEPTH - 1);

	op_t              entry_q [OPQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_full  = count_q == CNT_W'(OPQ_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/crs_back.sv
// ----------------------------------------------------------------------------
// crs_back
// Executes operations: owns the distance table, accumulates the saturating
// tour cost and queues the results for the receiver.
// ----------------------------------------------------------------------------
module crs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  crs_pkg::op_t    op_head,
	input  logic            op_empty,
	output logic            op_pop,
	input  logic            clear,
	input  logic            pop,
	output logic            empty,
	output crs_pkg::result_t result
);
	import crs_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OUT_DEPTH - 1);

	logic [DIST_BITS-1:0] table_mem [TABLE_DEPTH];

	op_t                  op_s1;
	logic                 valid_s1;
	logic [DIST_BITS-1:0] rdata_s1;
	logic [COST_W-1:0]    cost_q;

	result_t              res_q [OUT_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	logic                 take;
	logic [DIST_BITS-1:0] leg_dist;
	logic [COST_W:0]      cost_sum;
	logic [COST_W-1:0]    cost_new;
	logic                 res_push;
	logic                 res_pop;

	// Reserve a result slot for every operation in flight so the table read
	// never has to stall once issued.
	assign take   = ~op_empty && ((count_q + CNT_W'(valid_s1)) < CNT_W'(OUT_DEPTH));
	assign op_pop = take;

	always_ff @(posedge clk) begin
		if (take) begin
			if (op_head.kind == OP_WRITE && op_head.in_range) begin
				table_mem[op_head.addr] <= op_head.wdata;
			end
			rdata_s1 <= table_mem[op_head.addr];
			op_s1    <= op_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	// An entry outside the node range reads as zero distance.
	assign leg_dist = op_s1.in_range ? rdata_s1 : '0;
	assign cost_sum = {1'b0, cost_q} + (COST_W + 1)'(leg_dist);
	assign cost_new = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];

	assign res_push = valid_s1 && (op_s1.kind == OP_ADVANCE) && op_s1.emit;
	assign res_pop  = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q <= '0;
		end else if (clear) begin
			cost_q <= '0;
		end else if (valid_s1 && op_s1.kind == OP_ADVANCE) begin
			cost_q <= op_s1.last ? '0 : cost_new;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[wr_ptr_q] <= '{node: op_s1.node, route_cost: cost_new, last: op_s1.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (res_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({res_push, res_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign empty  = count_q == '0;
	assign result = res_q[rd_ptr_q];

endmodule

// File: rtl/core/capacity_route_splitter_core.sv
// ----------------------------------------------------------------------------
// capacity_route_splitter_core
// Splits a streamed giant tour into capacity-limited routes and prices them.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port: an item is taken on a clock edge
// with push high and full low. Load items fill the distance table, customer
// items stream the tour, and an end item closes it. Results leave the same
// way: the oldest result is shown while empty is low and is taken on an edge
// with pop high. Registers are written through cfg_we, cfg_index, cfg_data.
// A load or a plain customer yields one operation, a dropped depot customer
// none; a split customer or an end item yields two, and full stays high until
// its second one is queued. The front end hands one operation per cycle to the
// back end while the operation queue has room; each operation reads the table once.
// Reset clears the route state and the queues and restores the depot to
// node 0 and the capacity to 10; the distance table is not cleared and must
// be loaded before it is read. When the receiver stalls, four results and
// four operations are buffered before full rises.
// ----------------------------------------------------------------------------
module capacity_route_splitter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  crs_pkg::item_t                  item,
	output logic                            empty,
	input  logic                            pop,
	output crs_pkg::result_t                result,
	input  logic                            cfg_we,
	input  logic [crs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [crs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import crs_pkg::*;

	logic q_full;
	logic q_push;
	op_t  q_wdata;
	logic q_pop;
	op_t  q_head;
	logic q_empty;
	logic clear;

	crs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata),
		.clear     (clear)
	);

	crs_op_queue u_op_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (q_head),
		.q_empty (q_empty)
	);

	crs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_head  (q_head),
		.op_empty (q_empty),
		.op_pop   (q_pop),
		.clear    (clear),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

// File: rtl/core/crs_checker.sv
// ----------------------------------------------------------------------------
// crs_checker
// Port-level checks on the route splitter core, bound to its top level.
// ----------------------------------------------------------------------------
`include "capacity_route_splitter_core_macros.svh"

module crs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input crs_pkg::result_t result
);
	import crs_pkg::*;

	logic       accept;
	logic [7:0] quiet_hist_q;

	assign accept = push & ~full;

	// Marks cycles with no result waiting and no request taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_hist_q <= '0;
		end else begin
			quiet_hist_q <= {quiet_hist_q[6:0], empty & ~accept};
		end
	end

	// A waiting result stays in place until it is taken.
	`CRS_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))

	// Full only rises right after a request was taken.
	`CRS_ASSERT_SAME(a_full_after_accept, $rose(full), $past(push && !full))

	// After a long quiet spell nothing is left in flight to produce a result.
	`CRS_ASSERT_NEXT(a_no_stray_result, (&quiet_hist_q) && empty && !accept, empty)

endmodule

bind capacity_route_splitter_core crs_checker u_checker (.*);
